// ===== sv/ihsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ihsp_pkg
// Shared types, phase codes and constants for the image header size parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihsp_pkg;

  // Parse phase codes
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_SIG_PNG  = 4'd1;
  localparam logic [3:0] PH_SIG_JPEG = 4'd2;
  localparam logic [3:0] PH_PNG_BODY = 4'd3;
  localparam logic [3:0] PH_J_M0     = 4'd4;
  localparam logic [3:0] PH_J_M1     = 4'd5;
  localparam logic [3:0] PH_J_LEN_HI = 4'd6;
  localparam logic [3:0] PH_J_LEN_LO = 4'd7;
  localparam logic [3:0] PH_J_SKIP   = 4'd8;
  localparam logic [3:0] PH_J_SOF    = 4'd9;
  localparam logic [3:0] PH_HOLD     = 4'd10;
  localparam logic [3:0] PH_START    = 4'd11;

  // Format codes
  localparam logic [1:0] FMT_PNG     = 2'd0;
  localparam logic [1:0] FMT_JPEG    = 2'd1;
  localparam logic [1:0] FMT_NONE    = 2'd2;
  localparam logic [1:0] FMT_UNKNOWN = 2'd3;

  localparam int unsigned CAPTURED_BIT = 2;
  localparam logic [4:0]  MIN_FILE     = 5'd24;

  localparam logic [7:0] BYTE_PNG0 = 8'h89;
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_SOI  = 8'hD8;
  localparam logic [7:0] BYTE_SOF0 = 8'hC0;
  localparam logic [7:0] BYTE_SOF2 = 8'hC2;

  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [3:0]  phase;
    logic [4:0]  pos;
    logic [31:0] wcap;
    logic [31:0] hcap;
    logic [15:0] skip;
    logic [7:0]  len_hi;
    logic [2:0]  sof_idx;
    logic [2:0]  outcome;
  } parse_state_t;

  // Idle, no file open, format not yet known
  localparam parse_state_t PARSE_RESET = '{
    phase:   PH_IDLE,
    pos:     '0,
    wcap:    '0,
    hcap:    '0,
    skip:    '0,
    len_hi:  '0,
    sof_idx: '0,
    outcome: {1'b0, FMT_UNKNOWN}
  };

  typedef struct packed {
    logic        valid;
    logic        found;
    logic [1:0]  fmt;
    logic [30:0] width;
    logic [30:0] height;
  } parse_result_t;

  // PNG signature 89 50 4E 47 0D 0A 1A 0A
  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4E;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0D;
      3'd5:    v = 8'h0A;
      3'd6:    v = 8'h1A;
      3'd7:    v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ihsp_step.sv =====
// ----------------------------------------------------------------------------
// ihsp_step
// Per-byte next-state and result logic of the header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihsp_step (
  input  ihsp_pkg::parse_state_t  state_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    first_byte_i,
  input  logic                    end_of_file_i,
  output ihsp_pkg::parse_state_t  state_o,
  output ihsp_pkg::parse_result_t result_o
);

  always_comb begin
    ihsp_pkg::parse_state_t  s;
    ihsp_pkg::parse_result_t r;
    logic [4:0]              idx;
    logic [7:0]              b;
    logic [15:0]             len;
    logic [15:0]             skip_dec;
    logic [1:0]              fmt;
    logic                    found;

    s        = state_i;
    r        = '0;
    b        = data_byte_i;
    idx      = '0;
    len      = '0;
    skip_dec = '0;
    fmt      = '0;
    found    = 1'b0;

    if (first_byte_i) begin
      s.pos     = '0;
      s.wcap    = '0;
      s.hcap    = '0;
      s.skip    = '0;
      s.len_hi  = '0;
      s.sof_idx = '0;
      s.outcome = {1'b0, ihsp_pkg::FMT_UNKNOWN};
      s.phase   = ihsp_pkg::PH_START;
    end

    if (s.phase != ihsp_pkg::PH_IDLE) begin
      idx = s.pos;
      if (s.pos < ihsp_pkg::MIN_FILE) begin
        s.pos = s.pos + 5'd1;
      end

      case (s.phase)
        ihsp_pkg::PH_START: begin
          if (b == ihsp_pkg::BYTE_PNG0) begin
            s.phase = ihsp_pkg::PH_SIG_PNG;
          end else if (b == ihsp_pkg::BYTE_FF) begin
            s.phase = ihsp_pkg::PH_SIG_JPEG;
          end else begin
            s.outcome[1:0] = ihsp_pkg::FMT_NONE;
            s.phase        = ihsp_pkg::PH_HOLD;
          end
        end
        ihsp_pkg::PH_SIG_PNG: begin
          if (idx > 5'd7 || b != ihsp_pkg::png_sig_byte(idx[2:0])) begin
            s.outcome[1:0] = ihsp_pkg::FMT_NONE;
            s.phase        = ihsp_pkg::PH_HOLD;
          end else if (idx == 5'd7) begin
            s.outcome[1:0] = ihsp_pkg::FMT_PNG;
            s.phase        = ihsp_pkg::PH_PNG_BODY;
          end
        end
        ihsp_pkg::PH_SIG_JPEG: begin
          if (idx == 5'd1 && b == ihsp_pkg::BYTE_SOI) begin
            s.phase = ihsp_pkg::PH_SIG_JPEG;
          end else if (idx == 5'd2 && b == ihsp_pkg::BYTE_FF) begin
            // third signature byte doubles as the first marker's FF
            s.outcome[1:0] = ihsp_pkg::FMT_JPEG;
            s.phase        = ihsp_pkg::PH_J_M1;
          end else begin
            s.outcome[1:0] = ihsp_pkg::FMT_NONE;
            s.phase        = ihsp_pkg::PH_HOLD;
          end
        end
        ihsp_pkg::PH_PNG_BODY: begin
          if (idx >= 5'd16 && idx <= 5'd19) begin
            s.wcap = {s.wcap[23:0], b};
          end else if (idx >= 5'd20 && idx <= 5'd23) begin
            s.hcap = {s.hcap[23:0], b};
            if (idx == 5'd23) begin
              s.outcome[ihsp_pkg::CAPTURED_BIT] = 1'b1;
              s.phase = ihsp_pkg::PH_HOLD;
            end
          end
        end
        ihsp_pkg::PH_J_M0: begin
          s.phase = (b == ihsp_pkg::BYTE_FF) ? ihsp_pkg::PH_J_M1 : ihsp_pkg::PH_HOLD;
        end
        ihsp_pkg::PH_J_M1: begin
          if (b == ihsp_pkg::BYTE_SOF0 || b == ihsp_pkg::BYTE_SOF2) begin
            s.sof_idx = '0;
            s.phase   = ihsp_pkg::PH_J_SOF;
          end else begin
            s.phase = ihsp_pkg::PH_J_LEN_HI;
          end
        end
        ihsp_pkg::PH_J_LEN_HI: begin
          s.len_hi = b;
          s.phase  = ihsp_pkg::PH_J_LEN_LO;
        end
        ihsp_pkg::PH_J_LEN_LO: begin
          len = {s.len_hi, b};
          if (len < 16'd2) begin
            s.phase = ihsp_pkg::PH_HOLD;
          end else begin
            s.skip  = len - 16'd2;
            s.phase = (len == 16'd2) ? ihsp_pkg::PH_J_M0 : ihsp_pkg::PH_J_SKIP;
          end
        end
        ihsp_pkg::PH_J_SKIP: begin
          skip_dec = (s.skip != '0) ? s.skip - 16'd1 : s.skip;
          s.skip   = skip_dec;
          if (skip_dec == '0) begin
            s.phase = ihsp_pkg::PH_J_M0;
          end
        end
        ihsp_pkg::PH_J_SOF: begin
          case (s.sof_idx)
            3'd3: s.hcap = {24'd0, b};
            3'd4: s.hcap = {s.hcap[31:8], b} | {16'd0, s.hcap[7:0], 8'd0};
            3'd5: s.wcap = {24'd0, b};
            3'd6: begin
              s.wcap = {16'd0, s.wcap[7:0], b};
              s.outcome[ihsp_pkg::CAPTURED_BIT] = 1'b1;
              s.phase = ihsp_pkg::PH_HOLD;
            end
            default: s.hcap = s.hcap;
          endcase
          s.sof_idx = s.sof_idx + 3'd1;
        end
        default: s.phase = s.phase;
      endcase

      if (end_of_file_i) begin
        fmt   = (s.outcome[1:0] == ihsp_pkg::FMT_UNKNOWN) ? ihsp_pkg::FMT_NONE
                                                          : s.outcome[1:0];
        found = s.outcome[ihsp_pkg::CAPTURED_BIT] && (s.pos >= ihsp_pkg::MIN_FILE);
        r.valid  = 1'b1;
        r.found  = found;
        r.fmt    = fmt;
        r.width  = !found ? 31'd0 : (s.wcap[31] ? ihsp_pkg::SAT31 : s.wcap[30:0]);
        r.height = !found ? 31'd0 : (s.hcap[31] ? ihsp_pkg::SAT31 : s.hcap[30:0]);
        s.phase  = ihsp_pkg::PH_IDLE;
      end
    end

    state_o  = s;
    result_o = r;
  end

endmodule

// ===== sv/image_header_size_parser_core.sv =====
// A request's result reaches the output through the input register, one parse step and the
//   result register, and waits there until out_ready_i takes it.
// Throughput: one byte per cycle; the parse state update is one short step per byte.
// A waiting result holds the next byte in the input register, and then the input stalls.
// Reset (rst_ni low, asynchronous): parser goes idle waiting for a first byte,
//   input and result registers empty.
// ----------------------------------------------------------------------------
// image_header_size_parser_core
// Streams the bytes of an image file and reports PNG/JPEG width and height.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module image_header_size_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        end_of_file_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [1:0]  format_o,
  output logic [30:0] frame_width_o,
  output logic [30:0] frame_height_o
);

  // Input register stage
  logic       in_vld_q;
  logic       in_vld_d;
  logic [7:0] byte_q;
  logic       first_q;
  logic       last_q;

  // Parse state
  ihsp_pkg::parse_state_t  state_q;
  ihsp_pkg::parse_state_t  state_d;
  ihsp_pkg::parse_result_t step_res;

  // Result register
  logic        out_vld_q;
  logic        out_vld_d;
  logic        found_q;
  logic [1:0]  fmt_q;
  logic [30:0] width_q;
  logic [30:0] height_q;

  logic in_fire;
  logic s1_fire;

  // The staged byte moves through the parser only when the result slot can
  // take whatever it produces (slot empty, or being drained this cycle).
  assign s1_fire    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (s1_fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q  <= data_byte_i;
      first_q <= first_byte_i;
      last_q  <= end_of_file_i;
    end
  end

  ihsp_step u_step (
    .state_i       (state_q),
    .data_byte_i   (byte_q),
    .first_byte_i  (first_q),
    .end_of_file_i (last_q),
    .state_o       (state_d),
    .result_o      (step_res)
  );

  // Parse state advances once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ihsp_pkg::PARSE_RESET;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  // Result register: loaded on the last byte of a file, cleared when taken.
  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_fire && step_res.valid) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && step_res.valid) begin
      found_q  <= step_res.found;
      fmt_q    <= step_res.fmt;
      width_q  <= step_res.width;
      height_q <= step_res.height;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign found_o        = found_q;
  assign format_o       = fmt_q;
  assign frame_width_o  = width_q;
  assign frame_height_o = height_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_found_fmt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && found_q |-> (fmt_q == ihsp_pkg::FMT_PNG || fmt_q == ihsp_pkg::FMT_JPEG))
    else $error("found result with unrecognized format");

  a_zero_dims : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !found_q |-> (width_q == '0 && height_q == '0))
    else $error("nonzero dimensions on a failed parse");

  a_fmt_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (fmt_q != ihsp_pkg::FMT_UNKNOWN))
    else $error("unknown format code reported");

  a_idle_after : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && step_res.valid |=> (state_q.phase == ihsp_pkg::PH_IDLE))
    else $error("parser not idle after end of file");

  a_pos_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos <= ihsp_pkg::MIN_FILE)
    else $error("byte position beyond saturation");

endmodule
